@@ src/cau_pkg.sv @@
package cau_pkg;

    localparam int PART_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;
    localparam int KIND_WIDTH     = 3;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_ADD = 3'd0,
        KIND_SUB = 3'd1,
        KIND_MUL = 3'd2,
        KIND_DIV = 3'd3,
        KIND_MOD = 3'd4
    } t_kind;

endpackage

@@ src/cau_if.sv @@
interface cau_in_if #(parameter int PW = 16) (input logic i_clk);
    logic                 valid;
    logic                 ready;
    logic [2:0]           kind;
    logic signed [PW-1:0] a_re;
    logic signed [PW-1:0] a_im;
    logic signed [PW-1:0] b_re;
    logic signed [PW-1:0] b_im;
    modport source (output valid, kind, a_re, a_im, b_re, b_im, input ready);
    modport sink   (input valid, kind, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(parameter int PW = 16) (input logic i_clk);
    logic                 valid;
    logic                 ready;
    logic signed [PW-1:0] res_re;
    logic signed [PW-1:0] res_im;
    logic                 div_zero;
    logic                 saturated;
    modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
    modport sink   (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

@@ src/cau_core.sv @@
// Pipelined datapath. Stage 1 registers the products and add/sub results,
// stage 2 the product sums, then a shared stepping pipe does division /
// square root one bit per stage, then rounding and saturation.
module cau_core #(
    parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [2:0]                   i_kind,
    input  logic signed [PART_WIDTH-1:0] i_a_re,
    input  logic signed [PART_WIDTH-1:0] i_a_im,
    input  logic signed [PART_WIDTH-1:0] i_b_re,
    input  logic signed [PART_WIDTH-1:0] i_b_im,
    output logic                         o_valid,
    output logic signed [PART_WIDTH-1:0] o_res_re,
    output logic signed [PART_WIDTH-1:0] o_res_im,
    output logic                         o_div_zero,
    output logic                         o_saturated
);
    import cau_pkg::*;

    localparam int PW  = PART_WIDTH;
    localparam int PRW = 2 * PW + 2;            // signed sum of two products
    localparam int NW  = PRW;                   // numerator magnitude width
    localparam int DW  = 2 * PW + 1;            // denominator width
    // division: quotient bits PW+1 integer check + FRAC+1 fraction
    localparam int QB  = PW + FRAC_BITS + 2;
    localparam int XW  = NW + FRAC_BITS + 1;    // scaled numerator
    localparam int RW  = DW + 1;
    localparam int SB  = PW + 1;                // sqrt result bits
    localparam int STEPS = (QB > SB) ? QB : SB;
    localparam int SRW = 2 * SB + 2;

    typedef logic signed [PRW-1:0] t_wide;

    // ---------------- stage 1: products
    logic         r1_v;
    t_kind        r1_k;
    logic signed [PW:0] r1_add_re, r1_add_im;
    logic signed [2*PW-1:0] r1_ac, r1_bd, r1_ad, r1_bc, r1_cc, r1_dd, r1_aa, r1_bb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (i_en) begin
            r1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_k <= t_kind'(i_kind);
            if (i_kind == KIND_SUB) begin
                r1_add_re <= {i_a_re[PW-1], i_a_re} - {i_b_re[PW-1], i_b_re};
                r1_add_im <= {i_a_im[PW-1], i_a_im} - {i_b_im[PW-1], i_b_im};
            end else begin
                r1_add_re <= {i_a_re[PW-1], i_a_re} + {i_b_re[PW-1], i_b_re};
                r1_add_im <= {i_a_im[PW-1], i_a_im} + {i_b_im[PW-1], i_b_im};
            end
            r1_ac <= i_a_re * i_b_re;
            r1_bd <= i_a_im * i_b_im;
            r1_ad <= i_a_re * i_b_im;
            r1_bc <= i_a_im * i_b_re;
            r1_cc <= i_b_re * i_b_re;
            r1_dd <= i_b_im * i_b_im;
            r1_aa <= i_a_re * i_a_re;
            r1_bb <= i_a_im * i_a_im;
        end
    end

    // ---------------- stage 2: sums, split to sign and magnitude
    logic              r2_v;
    t_kind             r2_k;
    logic signed [PW:0] r2_add_re, r2_add_im;
    logic              r2_re_neg, r2_im_neg;
    logic [NW-1:0]     r2_re_mag, r2_im_mag;
    logic [DW-1:0]     r2_den;
    t_wide             n_re, n_im;

    always_comb begin
        if (r1_k == KIND_DIV) begin
            n_re = t_wide'(r1_ac) + t_wide'(r1_bd);
            n_im = t_wide'(r1_bc) - t_wide'(r1_ad);
        end else if (r1_k == KIND_MOD) begin
            n_re = t_wide'(r1_aa) + t_wide'(r1_bb);
            n_im = '0;
        end else begin
            n_re = t_wide'(r1_ac) - t_wide'(r1_bd);
            n_im = t_wide'(r1_ad) + t_wide'(r1_bc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (i_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_k      <= r1_k;
            r2_add_re <= r1_add_re;
            r2_add_im <= r1_add_im;
            r2_re_neg <= n_re[PRW-1];
            r2_im_neg <= n_im[PRW-1];
            r2_re_mag <= n_re[PRW-1] ? NW'(-n_re) : NW'(n_re);
            r2_im_mag <= n_im[PRW-1] ? NW'(-n_im) : NW'(n_im);
            r2_den    <= DW'($unsigned(r1_cc)) + DW'($unsigned(r1_dd));
        end
    end

    // ---------------- stepping pipe: restoring division on both parts, or
    // bit-pair square root of four times the radicand on the real part;
    // one result bit per stage
    logic          s_v    [STEPS+1];
    t_kind         s_k    [STEPS+1];
    logic signed [PW:0] s_are [STEPS+1], s_aim [STEPS+1];
    logic          s_rn   [STEPS+1], s_in [STEPS+1];
    logic          s_or   [STEPS+1], s_oi [STEPS+1];   // quotient overflow
    logic [NW-1:0] s_rm   [STEPS+1], s_im [STEPS+1];
    logic [DW-1:0] s_den  [STEPS+1];
    logic [XW-1:0] s_xr   [STEPS+1], s_xi [STEPS+1];   // numerator bits left
    logic [RW-1:0] s_rr   [STEPS+1], s_ri [STEPS+1];   // partial remainders
    logic [QB-1:0] s_qr   [STEPS+1], s_qi [STEPS+1];
    logic [SRW-1:0] s_sn  [STEPS+1];                   // sqrt remainder
    logic [SB-1:0] s_sq   [STEPS+1];

    always_comb begin
        s_v[0]   = r2_v;
        s_k[0]   = r2_k;
        s_are[0] = r2_add_re;
        s_aim[0] = r2_add_im;
        s_rn[0]  = r2_re_neg;
        s_in[0]  = r2_im_neg;
        s_rm[0]  = r2_re_mag;
        s_im[0]  = r2_im_mag;
        s_den[0] = r2_den;
        s_xr[0]  = XW'(r2_re_mag) << (FRAC_BITS + 1);
        s_xi[0]  = XW'(r2_im_mag) << (FRAC_BITS + 1);
        // the quotient does not fit QB bits when the leading bits already
        // reach the divisor
        s_or[0]  = (s_xr[0] >> QB) >= XW'(r2_den);
        s_oi[0]  = (s_xi[0] >> QB) >= XW'(r2_den);
        s_rr[0]  = '0;
        s_ri[0]  = '0;
        s_qr[0]  = '0;
        s_qi[0]  = '0;
        s_sn[0]  = '0;
        s_sq[0]  = '0;
    end

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        localparam int SQ_POS = (g < SB) ? 2 * (SB - 1 - g) : 0;

        logic [RW:0]    tr, ti;
        logic [RW-1:0]  nr, ni;
        logic [QB-1:0]  qr, qi;
        logic [XW-1:0]  xr, xi;
        logic [SRW-1:0] sn, trial;
        logic [SB-1:0]  sq;
        logic [1:0]     pair;
        logic [NW+1:0]  rad;

        always_comb begin
            // division: the first XW-QB numerator bits are shifted in
            // together at the first step
            nr = s_rr[g]; ni = s_ri[g]; qr = s_qr[g]; qi = s_qi[g];
            xr = s_xr[g]; xi = s_xi[g];
            if (g < QB) begin
                if (g == 0) begin
                    tr = (RW+1)'(s_xr[g] >> QB);
                    ti = (RW+1)'(s_xi[g] >> QB);
                    xr = s_xr[g] << (XW - QB);
                    xi = s_xi[g] << (XW - QB);
                end else begin
                    tr = (RW+1)'(s_rr[g]);
                    ti = (RW+1)'(s_ri[g]);
                end
                tr = {tr[RW-1:0], xr[XW-1]};
                ti = {ti[RW-1:0], xi[XW-1]};
                xr = xr << 1;
                xi = xi << 1;
                if (tr >= (RW+1)'(s_den[g])) begin
                    tr = tr - (RW+1)'(s_den[g]);
                    qr = {s_qr[g][QB-2:0], 1'b1};
                end else begin
                    qr = {s_qr[g][QB-2:0], 1'b0};
                end
                if (ti >= (RW+1)'(s_den[g])) begin
                    ti = ti - (RW+1)'(s_den[g]);
                    qi = {s_qi[g][QB-2:0], 1'b1};
                end else begin
                    qi = {s_qi[g][QB-2:0], 1'b0};
                end
                nr = tr[RW-1:0];
                ni = ti[RW-1:0];
            end else begin
                tr = '0;
                ti = '0;
            end
            // square root: one bit pair of the radicand per step; the extra
            // result bit below the point sets the rounding
            sn = s_sn[g]; sq = s_sq[g]; pair = '0; trial = '0;
            rad = {s_rm[g], 2'b00};
            if (g < SB) begin
                pair  = rad[SQ_POS +: 2];
                sn    = {s_sn[g][SRW-3:0], pair};
                trial = SRW'({s_sq[g], 2'b01});
                if (sn >= trial) begin
                    sn = sn - trial;
                    sq = {s_sq[g][SB-2:0], 1'b1};
                end else begin
                    sq = {s_sq[g][SB-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                s_v[g+1] <= 1'b0;
            end else if (i_en) begin
                s_v[g+1] <= s_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                s_k[g+1]   <= s_k[g];
                s_are[g+1] <= s_are[g];
                s_aim[g+1] <= s_aim[g];
                s_rn[g+1]  <= s_rn[g];
                s_in[g+1]  <= s_in[g];
                s_or[g+1]  <= s_or[g];
                s_oi[g+1]  <= s_oi[g];
                s_rm[g+1]  <= s_rm[g];
                s_im[g+1]  <= s_im[g];
                s_den[g+1] <= s_den[g];
                s_xr[g+1]  <= xr;
                s_xi[g+1]  <= xi;
                s_rr[g+1]  <= nr;
                s_ri[g+1]  <= ni;
                s_qr[g+1]  <= qr;
                s_qi[g+1]  <= qi;
                s_sn[g+1]  <= sn;
                s_sq[g+1]  <= sq;
            end
        end
    end

    // ---------------- final stage: round and saturate
    localparam logic [NW:0] HALF = (FRAC_BITS > 0) ? (NW+1)'(1) << (FRAC_BITS > 0 ?
                                   FRAC_BITS - 1 : 0) : '0;
    localparam logic [NW:0] POS_LIM = (NW+1)'((65'd1 << (PW - 1)) - 65'd1);
    localparam logic [NW:0] NEG_LIM = (NW+1)'(65'd1 << (PW - 1));
    localparam logic [NW:0] OVF_MAG = (NW+1)'(1) << PW;

    logic              f_v;
    logic              f_neg_re, f_neg_im;
    logic [NW:0]       f_mag_re, f_mag_im;
    logic              f_dz, f_zero;
    logic [PW-1:0]     f_re, f_im;
    logic              f_sat_re, f_sat_im;
    logic [QB-1:0]     qr_f, qi_f;
    logic [NW:0]       lim_re, lim_im;

    always_comb begin
        f_v      = s_v[STEPS];
        f_dz     = 1'b0;
        f_zero   = 1'b0;
        f_neg_re = 1'b0;
        f_neg_im = 1'b0;
        f_mag_re = '0;
        f_mag_im = '0;
        qr_f     = s_qr[QB];
        qi_f     = s_qi[QB];
        unique case (s_k[STEPS])
            KIND_ADD, KIND_SUB: begin
                f_neg_re = s_are[STEPS][PW];
                f_neg_im = s_aim[STEPS][PW];
                f_mag_re = f_neg_re ? (NW+1)'(-s_are[STEPS]) : (NW+1)'(s_are[STEPS]);
                f_mag_im = f_neg_im ? (NW+1)'(-s_aim[STEPS]) : (NW+1)'(s_aim[STEPS]);
            end
            KIND_MUL: begin
                f_neg_re = s_rn[STEPS];
                f_neg_im = s_in[STEPS];
                f_mag_re = ((NW+1)'(s_rm[STEPS]) + HALF) >> FRAC_BITS;
                f_mag_im = ((NW+1)'(s_im[STEPS]) + HALF) >> FRAC_BITS;
            end
            KIND_DIV: begin
                if (s_den[STEPS] == '0) begin
                    f_dz = 1'b1;
                end else begin
                    f_neg_re = s_rn[STEPS];
                    f_neg_im = s_in[STEPS];
                    // a quotient that overflows QB bits saturates whatever its rounding
                    f_mag_re = s_or[STEPS] ? OVF_MAG
                                           : ((NW+1)'(qr_f) + (NW+1)'(1)) >> 1;
                    f_mag_im = s_oi[STEPS] ? OVF_MAG
                                           : ((NW+1)'(qi_f) + (NW+1)'(1)) >> 1;
                end
            end
            KIND_MOD: begin
                f_mag_re = (NW+1)'(s_sq[STEPS] >> 1) + (NW+1)'(s_sq[STEPS][0]);
            end
            default: begin
                f_zero = 1'b1;
            end
        endcase
        if (f_mag_re == '0) f_neg_re = 1'b0;
        if (f_mag_im == '0) f_neg_im = 1'b0;
        lim_re   = f_neg_re ? NEG_LIM : POS_LIM;
        lim_im   = f_neg_im ? NEG_LIM : POS_LIM;
        f_sat_re = f_mag_re > lim_re;
        f_sat_im = f_mag_im > lim_im;
        f_re = f_sat_re ? PW'(lim_re) : PW'(f_mag_re);
        f_im = f_sat_im ? PW'(lim_im) : PW'(f_mag_im);
        if (f_neg_re) f_re = -f_re;
        if (f_neg_im) f_im = -f_im;
        if (f_zero) begin
            f_re = '0;
            f_im = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res_re    <= f_re;
            o_res_im    <= f_im;
            o_div_zero  <= f_dz;
            o_saturated <= f_sat_re | f_sat_im;
        end
    end
endmodule

@@ src/complex_arithmetic_unit.sv @@
// Channel   Dir  Payload
// in_ch     in   kind, a_re, a_im, b_re, b_im
// out_ch    out  res_re, res_im, div_zero, saturated
//
// One item per cycle while out_ch is not stalled; the pipe depth is set by
// the bit-per-stage division pipe.
// Synchronous active-low reset clears all valid bits.
// A stall on the output freezes the whole pipe; in_ch.ready follows
// out_ch.ready or an empty output slot, so nothing is lost or repeated.
module complex_arithmetic_unit #(
    parameter int PART_WIDTH = cau_pkg::PART_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cau_in_if.sink      in_ch,
    cau_out_if.source   out_ch
);
    import cau_pkg::*;

    logic en;

    // advance when the output slot is free or being taken
    assign en           = out_ch.ready | ~out_ch.valid;
    assign in_ch.ready  = en;

    cau_core #(
        .PART_WIDTH (PART_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (in_ch.valid),
        .i_kind      (in_ch.kind),
        .i_a_re      (in_ch.a_re),
        .i_a_im      (in_ch.a_im),
        .i_b_re      (in_ch.b_re),
        .i_b_im      (in_ch.b_im),
        .o_valid     (out_ch.valid),
        .o_res_re    (out_ch.res_re),
        .o_res_im    (out_ch.res_im),
        .o_div_zero  (out_ch.div_zero),
        .o_saturated (out_ch.saturated)
    );
endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import cau_pkg::*;

    localparam int PW      = 16;
    localparam int FB      = 8;
    localparam int LATENCY = PW + FB + 5;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [2:0]           kind;
        logic signed [PW-1:0] a_re;
        logic signed [PW-1:0] a_im;
        logic signed [PW-1:0] b_re;
        logic signed [PW-1:0] b_im;
    } t_op;

    typedef struct packed {
        logic signed [PW-1:0] re;
        logic signed [PW-1:0] im;
        logic                 div_zero;
        logic                 saturated;
    } t_res;

    logic i_clk;
    logic i_rst_n;

    cau_in_if  #(.PW(PW)) in_ch  (.i_clk(i_clk));
    cau_out_if #(.PW(PW)) out_ch (.i_clk(i_clk));

    complex_arithmetic_unit #(.PART_WIDTH(PW), .FRAC_BITS(FB)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    t_res   expected_results[$];
    int     mismatches;
    longint cycles;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Clamp a wide signed value to the part range.
    function automatic logic [PW-1:0] clamp(input longint v, inout logic sat);
        longint hi, lo;
        hi = (64'sd1 <<< (PW - 1)) - 1;
        lo = -(64'sd1 <<< (PW - 1));
        if (v > hi) begin
            sat = 1'b1;
            return hi[PW-1:0];
        end
        if (v < lo) begin
            sat = 1'b1;
            return lo[PW-1:0];
        end
        return v[PW-1:0];
    endfunction

    // Drop fraction bits, rounding half away from zero.
    function automatic longint round_frac(input longint v);
        longint m;
        m = (v < 0) ? -v : v;
        m = (m + (64'sd1 <<< (FB - 1))) >>> FB;
        return (v < 0) ? -m : m;
    endfunction

    // Quotient n*2^FB/den, rounded half away from zero.
    function automatic longint div_round(input longint n, input longint den);
        longint m, q;
        m = (n < 0) ? -n : n;
        if (m / den >= (64'sd1 <<< PW)) q = 64'sd1 <<< PW;
        else q = ((m <<< (FB + 1)) / den + 1) >>> 1;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint sqrt_nearest(input longint n);
        longint r;
        r = 0;
        for (int k = 31; k >= 0; k--)
            if ((r + (64'sd1 <<< k)) * (r + (64'sd1 <<< k)) <= n) r += 64'sd1 <<< k;
        // nearest: n - r^2 > r  means closer to r+1
        if (n - r * r > r) r++;
        return r;
    endfunction

    function automatic t_res complex_result(input t_op op);
        t_res   r;
        longint a, b, c, d, den;
        logic   sat;
        a = op.a_re; b = op.a_im; c = op.b_re; d = op.b_im;
        r = '0;
        sat = 1'b0;
        case (op.kind)
            KIND_ADD: begin
                r.re = clamp(a + c, sat);
                r.im = clamp(b + d, sat);
            end
            KIND_SUB: begin
                r.re = clamp(a - c, sat);
                r.im = clamp(b - d, sat);
            end
            KIND_MUL: begin
                r.re = clamp(round_frac(a * c - b * d), sat);
                r.im = clamp(round_frac(a * d + b * c), sat);
            end
            KIND_DIV: begin
                den = c * c + d * d;
                if (den == 0) r.div_zero = 1'b1;
                else begin
                    r.re = clamp(div_round(a * c + b * d, den), sat);
                    r.im = clamp(div_round(b * c - a * d, den), sat);
                end
            end
            KIND_MOD: r.re = clamp(sqrt_nearest(a * a + b * b), sat);
            default: ;
        endcase
        r.saturated = sat;
        return r;
    endfunction

    // Leave valid high after the transfer; drain, or a random gap in the next call, drops it.
    task automatic send_op(input t_op op);
        int gap;
        gap = $urandom_range(0, 12);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        {in_ch.kind, in_ch.a_re, in_ch.a_im, in_ch.b_re, in_ch.b_im} <= op;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        expected_results.push_back(complex_result(op));
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [PW-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return {1'b1, {(PW-1){1'b0}}};
            1: return {1'b0, {(PW-1){1'b1}}};
            2: return PW'($signed($urandom_range(0, 1023)) - 512);
            default: return PW'($urandom);
        endcase
    endfunction

    task automatic test_directed;
        logic [PW-1:0] mx, mn, one;
        mx  = {1'b0, {(PW-1){1'b1}}};
        mn  = {1'b1, {(PW-1){1'b0}}};
        one = PW'(1 << FB);
        send_op({3'(KIND_ADD), mx, mx, mx, mx});
        send_op({3'(KIND_ADD), mn, mn, mn, mn});
        send_op({3'(KIND_SUB), mx, mn, mn, mx});
        send_op({3'(KIND_SUB), one, one, one, one});
        send_op({3'(KIND_MUL), mn, mn, mn, mn});
        send_op({3'(KIND_MUL), mx, mn, mx, mx});
        send_op({3'(KIND_MUL), one, one, one, -one});
        send_op({3'(KIND_MUL), PW'(1), PW'(128), PW'(1), PW'(1)});
        send_op({3'(KIND_DIV), one, one, PW'(0), PW'(0)});
        send_op({3'(KIND_DIV), mx, mx, PW'(1), PW'(0)});
        send_op({3'(KIND_DIV), mn, mn, PW'(-1), PW'(1)});
        send_op({3'(KIND_DIV), one, -one, one, one});
        send_op({3'(KIND_DIV), PW'(1), PW'(0), mn, mn});
        send_op({3'(KIND_MOD), mn, mn, PW'(0), PW'(0)});
        send_op({3'(KIND_MOD), mx, PW'(0), mx, mx});
        send_op({3'(KIND_MOD), PW'(768), PW'(1024), PW'(0), PW'(0)});
        send_op({3'd5, one, one, one, one});
        send_op({3'd6, mn, mx, mn, mx});
        send_op({3'd7, mx, mn, PW'(0), PW'(0)});
    endtask

    task automatic test_random(input int count);
        t_op op;
        for (int n = 0; n < count; n++) begin
            op.kind = $urandom_range(0, 9) < 8 ? 3'($urandom_range(0, 4))
                                               : 3'($urandom_range(5, 7));
            op.a_re = rand_part();
            op.a_im = rand_part();
            op.b_re = rand_part();
            op.b_im = rand_part();
            if (op.kind == KIND_DIV && $urandom_range(0, 15) == 0) begin
                op.b_re = '0;
                op.b_im = '0;
            end
            send_op(op);
        end
    endtask

    // Leave valid high at the end; the following test drives it next.
    task automatic test_back_to_back(input int count);
        t_op op;
        for (int n = 0; n < count; n++) begin
            op = {3'($urandom_range(0, 4)), rand_part(), rand_part(), rand_part(),
                  rand_part()};
            in_ch.valid <= 1'b1;
            {in_ch.kind, in_ch.a_re, in_ch.a_im, in_ch.b_re, in_ch.b_im} <= op;
            @(posedge i_clk);
            while (!in_ch.ready) @(posedge i_clk);
            expected_results.push_back(complex_result(op));
        end
    endtask

    // Random stalls on the result side, with stall-free stretches.
    initial begin
        int hold;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
                if (cycles > 200 && cycles < 1500) hold = 0;
                if (hold != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (hold) @(posedge i_clk);
                end
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_res got, exp_r;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = {out_ch.res_re, out_ch.res_im, out_ch.div_zero, out_ch.saturated};
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer: %p", got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got !== exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected re=%0d im=%0d dz=%b sat=%b,",
                                 exp_r.re, exp_r.im, exp_r.div_zero, exp_r.saturated,
                                 " got re=%0d im=%0d dz=%b sat=%b",
                                 got.re, got.im, got.div_zero, got.saturated);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    initial begin
        cycles        = 0;
        mismatches    = 0;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.kind    = '0;
        in_ch.a_re    = '0;
        in_ch.a_im    = '0;
        in_ch.b_re    = '0;
        in_ch.b_im    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        drain();
        test_back_to_back(150);
        test_random(680);
        drain();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS complex_arithmetic_unit");
        end else begin
            $display("FAIL complex_arithmetic_unit");
        end
        $finish;
    end

endmodule
